// ----- hdl/orol_pkg.sv -----
// ----------------------------------------------------------------------------
// orol_pkg
// Shared types and constants for the overwriting ring offset lookup: field
// widths, action codes and the walk result handed to the top level.
// ----------------------------------------------------------------------------
package orol_pkg;

    // Default ring depth.
    localparam int SLOTS_DEF = 16;

    // Payload field widths.
    localparam int REF_W      = 32;
    localparam int SIZE_W     = 20;
    localparam int OFF_W      = 24;
    localparam int HIT_SLOT_W = 4;

    // Action codes carried on the action port.
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    // Outcome of one find walk, valid in the cycle done is high.
    typedef struct packed {
        logic                  done;
        logic                  found;
        logic [HIT_SLOT_W-1:0] slot;
        logic [SIZE_W-1:0]     offset;
    } walk_res_t;

endpackage

// ----- hdl/orol_ram.sv -----
// ----------------------------------------------------------------------------
// orol_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module orol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/orol_walk.sv -----
// ----------------------------------------------------------------------------
// orol_walk
// Find sequencer. Steps through the valid entries oldest first, one memory
// word per cycle, subtracting sizes until the offset falls inside an entry
// or the valid entries run out.
// ----------------------------------------------------------------------------
module orol_walk
    import orol_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [$clog2(SLOTS)-1:0]   start_slot,
    input  logic [$clog2(SLOTS+1)-1:0] count,
    input  logic [OFF_W-1:0]           offset,
    output logic [$clog2(SLOTS)-1:0]   rd_addr,
    input  logic [SIZE_W-1:0]          rd_size,
    output logic                       busy,
    output walk_res_t                  res
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    typedef enum logic {
        W_IDLE,
        W_SCAN
    } wstate_t;

    wstate_t             state_reg;
    wstate_t             state_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [SLOT_W-1:0]   slot_inc;
    logic [CNT_W-1:0]    left_reg;
    logic [CNT_W-1:0]    left_next;
    logic [OFF_W-1:0]    off_reg;
    logic [OFF_W-1:0]    off_next;
    logic                hit;

    // Wrapping increment of the slot whose word arrives this cycle.
    assign slot_inc = (slot_reg == SLOT_W'(SLOTS - 1)) ? '0 : slot_reg + 1'b1;

    // The next word is fetched ahead; a hit simply leaves it unused.
    assign rd_addr = (state_reg == W_IDLE) ? start_slot : slot_inc;
    assign busy    = (state_reg != W_IDLE);
    assign hit     = (off_reg < {{(OFF_W - SIZE_W){1'b0}}, rd_size});

    // Next state and the result of the current step.
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        left_next  = left_reg;
        off_next   = off_reg;
        res        = '0;
        unique case (state_reg)
            W_IDLE:
            begin
                if (go)
                begin
                    slot_next = start_slot;
                    left_next = count;
                    off_next  = offset;
                    if (count == '0)
                    begin
                        res.done = 1'b1;
                    end
                    else
                    begin
                        state_next = W_SCAN;
                    end
                end
            end
            W_SCAN:
            begin
                if (hit)
                begin
                    res.done   = 1'b1;
                    res.found  = 1'b1;
                    res.slot   = HIT_SLOT_W'(slot_reg);
                    res.offset = off_reg[SIZE_W-1:0];
                    state_next = W_IDLE;
                end
                else if (left_reg == CNT_W'(1))
                begin
                    res.done   = 1'b1;
                    state_next = W_IDLE;
                end
                else
                begin
                    off_next  = off_reg - {{(OFF_W - SIZE_W){1'b0}}, rd_size};
                    slot_next = slot_inc;
                    left_next = left_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    // Sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            slot_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            left_reg  <= left_next;
        end
    end

    // Running offset needs no reset.
    always_ff @(posedge clk)
    begin
        off_reg <= off_next;
    end

endmodule

// ----- hdl/overwriting_ring_offset_lookup.sv -----
// An add word gives its result in the cycle after start is taken.
// A find walks the valid entries oldest first, one entry per cycle while busy,
// set by the one-word-per-cycle read port of the entry memory.
// A new word is taken while busy is low; only a find raises busy.
// Reset clears the indices and the full flag; entry memory holds no reset.
// Results are strobed on done for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// overwriting_ring_offset_lookup
// Ring of entries with overwrite of the oldest; a find locates a byte
// offset in the entries joined oldest first.
// ----------------------------------------------------------------------------
module overwriting_ring_offset_lookup
    import orol_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [REF_W-1:0]      entry_ref,
    input  logic [SIZE_W-1:0]     entry_size,
    input  logic [OFF_W-1:0]      byte_offset,
    output logic                  done,
    output logic                  found,
    output logic [HIT_SLOT_W-1:0] hit_slot,
    output logic [REF_W-1:0]      hit_ref,
    output logic [SIZE_W-1:0]     offset_in_entry,
    output logic                  ring_full
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int WORD_W = REF_W + SIZE_W;

    logic [SLOT_W-1:0] wr_idx_reg;
    logic [SLOT_W-1:0] wr_idx_next;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic [SLOT_W-1:0] rd_idx_next;
    logic              full_reg;
    logic              full_next;
    logic              add_go;
    logic              find_go;
    logic [CNT_W-1:0]  valid_cnt;
    logic [SLOT_W-1:0] ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              walk_busy;
    walk_res_t         walk_res;

    logic                  done_reg;
    logic                  found_reg;
    logic [HIT_SLOT_W-1:0] hit_slot_reg;
    logic [REF_W-1:0]      hit_ref_reg;
    logic [SIZE_W-1:0]     offset_in_entry_reg;
    logic                  ring_full_reg;

    assign busy    = walk_busy;
    assign add_go  = start && !walk_busy && (action == ACT_ADD);
    assign find_go = start && !walk_busy && (action == ACT_FIND);

    // Index update for an add: a full ring drops its oldest entry first.
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (full_reg)
        begin
            rd_idx_next = (rd_idx_reg == SLOT_W'(SLOTS - 1)) ? '0 : rd_idx_reg + 1'b1;
        end
        wr_idx_next = (wr_idx_reg == SLOT_W'(SLOTS - 1)) ? '0 : wr_idx_reg + 1'b1;
        full_next   = (wr_idx_next == rd_idx_next);
    end

    // Number of valid entries between read and write index.
    always_comb
    begin
        if (full_reg)
        begin
            valid_cnt = CNT_W'(SLOTS);
        end
        else if (wr_idx_reg >= rd_idx_reg)
        begin
            valid_cnt = CNT_W'(wr_idx_reg) - CNT_W'(rd_idx_reg);
        end
        else
        begin
            valid_cnt = CNT_W'(wr_idx_reg) + CNT_W'(SLOTS) - CNT_W'(rd_idx_reg);
        end
    end

    // Ring pointers and full flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            full_reg   <= 1'b0;
        end
        else if (add_go)
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            full_reg   <= full_next;
        end
    end

    // Entry memory: reference in the upper bits, size in the lower bits.
    orol_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (add_go),
        .waddr (wr_idx_reg),
        .wdata ({entry_ref, entry_size}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    orol_walk #(
        .SLOTS (SLOTS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (find_go),
        .start_slot (rd_idx_reg),
        .count      (valid_cnt),
        .offset     (byte_offset),
        .rd_addr    (ram_raddr),
        .rd_size    (ram_rdata[SIZE_W-1:0]),
        .busy       (walk_busy),
        .res        (walk_res)
    );

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= add_go || walk_res.done;
        end
    end

    // Result word; the memory word still shows the hit entry this cycle.
    always_ff @(posedge clk)
    begin
        if (add_go)
        begin
            found_reg           <= 1'b0;
            hit_slot_reg        <= '0;
            hit_ref_reg         <= '0;
            offset_in_entry_reg <= '0;
            ring_full_reg       <= full_next;
        end
        else if (walk_res.done)
        begin
            found_reg           <= walk_res.found;
            hit_slot_reg        <= walk_res.slot;
            hit_ref_reg         <= walk_res.found ? ram_rdata[WORD_W-1:SIZE_W] : '0;
            offset_in_entry_reg <= walk_res.offset;
            ring_full_reg       <= full_reg;
        end
    end

    assign done            = done_reg;
    assign found           = found_reg;
    assign hit_slot        = hit_slot_reg;
    assign hit_ref         = hit_ref_reg;
    assign offset_in_entry = offset_in_entry_reg;
    assign ring_full       = ring_full_reg;

endmodule

// ----- hdl/orol_checker.sv -----
// ----------------------------------------------------------------------------
// orol_checker
// Port-level checks on the ring lookup, attached to the top level by bind.
// ----------------------------------------------------------------------------
module orol_checker
    import orol_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  action,
    input logic                  done,
    input logic                  found,
    input logic [HIT_SLOT_W-1:0] hit_slot,
    input logic [REF_W-1:0]      hit_ref,
    input logic [SIZE_W-1:0]     offset_in_entry
);

    // An add word answers in the next cycle and never reports a hit.
    a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_ADD)) |=> (done && !found))
        else $error("add word did not produce a plain result");

    // A find word either answers at once or holds the block busy.
    a_find_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_FIND)) |=> (done || busy))
        else $error("find word neither answered nor started a walk");

    // A result closes the word, so the block is free in that cycle.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    // A miss carries no slot, reference or position.
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> ((hit_slot == '0) && (hit_ref == '0)
                              && (offset_in_entry == '0)))
        else $error("miss result carries stale fields");

endmodule

bind overwriting_ring_offset_lookup orol_checker u_orol_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .action          (action),
    .done            (done),
    .found           (found),
    .hit_slot        (hit_slot),
    .hit_ref         (hit_ref),
    .offset_in_entry (offset_in_entry)
);

// ----- tb/tb_overwriting_ring_offset_lookup.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_overwriting_ring_offset_lookup
// Self-checking bench for the overwriting ring offset lookup. A short table of
// directed words covers the empty ring, field extremes, zero-size entries,
// the first wrap to full and an overwrite. A long random run follows, with
// offsets aimed at entry boundaries and at the end of the stored data. Each
// result is checked field by field against a model of the ring or a pinned reply.
// ----------------------------------------------------------------------------
module tb_overwriting_ring_offset_lookup;
    import orol_pkg::*;

    localparam int RING_SLOTS    = SLOTS_DEF;
    localparam int RANDOM_WORDS  = 1700;
    localparam int REPORT_LIMIT  = 10;
    localparam int DRAIN_LIMIT   = 4000;

    // One result word as the block reports it.
    typedef struct packed {
        logic                  found;
        logic [HIT_SLOT_W-1:0] slot;
        logic [REF_W-1:0]      data_ref;
        logic [SIZE_W-1:0]     offset;
        logic                  full;
    } ring_reply_t;

    // One row of the directed table; pinned rows carry their own reply.
    typedef struct packed {
        logic              action;
        logic [REF_W-1:0]  data_ref;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  offset;
        logic              pinned;
        ring_reply_t       reply;
    } script_row_t;

    localparam ring_reply_t NO_REPLY = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  action;
    logic [REF_W-1:0]      entry_ref;
    logic [SIZE_W-1:0]     entry_size;
    logic [OFF_W-1:0]      byte_offset;
    logic                  done;
    logic                  found;
    logic [HIT_SLOT_W-1:0] hit_slot;
    logic [REF_W-1:0]      hit_ref;
    logic [SIZE_W-1:0]     offset_in_entry;
    logic                  ring_full;

    // Reply typed into the table for the word now on the inputs.
    logic                  pin_valid;
    ring_reply_t           pin_reply;

    // Model of the ring contents and indexes.
    logic [REF_W-1:0]      ring_refs  [RING_SLOTS];
    logic [SIZE_W-1:0]     ring_sizes [RING_SLOTS];
    int unsigned           ring_wr;
    int unsigned           ring_rd;
    bit                    ring_is_full;

    ring_reply_t           pending_replies[$];
    script_row_t           script_rows[$];
    int unsigned           mismatch_count;
    bit                    sender_may_idle;

    overwriting_ring_offset_lookup dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .entry_ref       (entry_ref),
        .entry_size      (entry_size),
        .byte_offset     (byte_offset),
        .done            (done),
        .found           (found),
        .hit_slot        (hit_slot),
        .hit_ref         (hit_ref),
        .offset_in_entry (offset_in_entry),
        .ring_full       (ring_full)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Safety net against a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // Number of entries currently holding data.
    function automatic int unsigned live_entries();
        if (ring_is_full)
        begin
            return RING_SLOTS;
        end
        return (ring_wr + RING_SLOTS - ring_rd) % RING_SLOTS;
    endfunction

    // Bytes held by the oldest k live entries.
    function automatic logic [31:0] bytes_before(int unsigned k);
        logic [31:0] sum;
        int unsigned slot;
        sum  = '0;
        slot = ring_rd;
        for (int unsigned i = 0; i < k; i++)
        begin
            sum  = sum + 32'(ring_sizes[slot]);
            slot = (slot + 1) % RING_SLOTS;
        end
        return sum;
    endfunction

    // Apply one word to the ring model and return the reply it causes.
    function automatic ring_reply_t apply_ring_word(logic act, logic [REF_W-1:0] dref,
                                                    logic [SIZE_W-1:0] size,
                                                    logic [OFF_W-1:0] off);
        ring_reply_t reply;
        logic [31:0] remaining;
        int unsigned slot;
        int unsigned count;
        reply = NO_REPLY;
        if (act == ACT_ADD)
        begin
            // A full ring drops its oldest entry before the write.
            if (ring_is_full)
            begin
                ring_rd = (ring_rd + 1) % RING_SLOTS;
            end
            ring_refs[ring_wr]  = dref;
            ring_sizes[ring_wr] = size;
            ring_wr             = (ring_wr + 1) % RING_SLOTS;
            ring_is_full        = (ring_wr == ring_rd);
        end
        else
        begin
            // Walk live entries oldest first, consuming their sizes.
            remaining = 32'(off);
            slot      = ring_rd;
            count     = live_entries();
            for (int unsigned i = 0; i < count; i++)
            begin
                if (remaining < 32'(ring_sizes[slot]))
                begin
                    reply.found    = 1'b1;
                    reply.slot     = HIT_SLOT_W'(slot);
                    reply.data_ref = ring_refs[slot];
                    reply.offset   = SIZE_W'(remaining);
                    break;
                end
                remaining = remaining - 32'(ring_sizes[slot]);
                slot      = (slot + 1) % RING_SLOTS;
            end
        end
        reply.full = ring_is_full;
        return reply;
    endfunction

    // Compare one result field and report the first few mismatches.
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
            begin
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    // Score results, then record the expectation of any word taken at this edge.
    always @(posedge clk)
    begin
        ring_reply_t want;
        ring_reply_t predicted;
        if (done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("%0t: result word with no expectation pending", $time);
                end
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("found", 32'(want.found), 32'(found));
                check_field("hit_slot", 32'(want.slot), 32'(hit_slot));
                check_field("hit_ref", want.data_ref, hit_ref);
                check_field("offset_in_entry", 32'(want.offset), 32'(offset_in_entry));
                check_field("ring_full", 32'(want.full), 32'(ring_full));
            end
        end
        if (rst_n && start && !busy)
        begin
            predicted = apply_ring_word(action, entry_ref, entry_size, byte_offset);
            pending_replies.push_back(pin_valid ? pin_reply : predicted);
        end
    end

    // Present one word at the falling edge and hold it until it is taken.
    task automatic send_word(logic act, logic [REF_W-1:0] dref, logic [SIZE_W-1:0] size,
                             logic [OFF_W-1:0] off, logic pinned, ring_reply_t reply);
        @(negedge clk);
        if (sender_may_idle)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start       <= 1'b1;
        action      <= act;
        entry_ref   <= dref;
        entry_size  <= size;
        byte_offset <= off;
        pin_valid   <= pinned;
        pin_reply   <= reply;
        do
        begin
            @(posedge clk);
        end
        while (busy);
    endtask

    // Directed table row helper.
    function automatic void script(logic act, logic [REF_W-1:0] dref, logic [SIZE_W-1:0] size,
                                   logic [OFF_W-1:0] off, logic pinned, ring_reply_t reply);
        script_rows.push_back('{act, dref, size, off, pinned, reply});
    endfunction

    // Stimulus: reset, directed table, random words, drain and verdict.
    initial
    begin
        script_row_t      row;
        int unsigned      add_pct;
        int unsigned      live;
        int unsigned      pick;
        logic             act;
        logic [31:0]      total;
        logic [31:0]      target;
        logic [SIZE_W-1:0] size;
        int unsigned      drain;

        rst_n           = 1'b0;
        start           = 1'b0;
        action          = ACT_ADD;
        entry_ref       = '0;
        entry_size      = '0;
        byte_offset     = '0;
        pin_valid       = 1'b0;
        pin_reply       = NO_REPLY;
        ring_wr         = 0;
        ring_rd         = 0;
        ring_is_full    = 1'b0;
        mismatch_count  = 0;
        sender_may_idle = 1'b1;
        for (int i = 0; i < RING_SLOTS; i++)
        begin
            ring_refs[i]  = '0;
            ring_sizes[i] = '0;
        end

        // Empty ring, extremes, a zero-size entry, fill to full, then overwrite.
        script(ACT_FIND, 32'h0, 20'h0, 24'h000000, 1'b1, '{1'b0, 4'h0, 32'h0, 20'h0, 1'b0});
        script(ACT_FIND, 32'hFFFFFFFF, 20'hFFFFF, 24'hFFFFFF, 1'b1, NO_REPLY);
        script(ACT_ADD, 32'hFFFFFFFF, 20'hFFFFF, 24'hFFFFFF, 1'b1, NO_REPLY);
        script(ACT_ADD, 32'h00000000, 20'h00000, 24'h000000, 1'b1, NO_REPLY);
        script(ACT_ADD, 32'hA5A5A5A5, 20'h00001, 24'h5A5A5A, 1'b1, NO_REPLY);
        script(ACT_FIND, 32'h0, 20'h0, 24'h000000, 1'b1,
               '{1'b1, 4'h0, 32'hFFFFFFFF, 20'h00000, 1'b0});
        script(ACT_FIND, 32'h0, 20'h0, 24'h0FFFFE, 1'b1,
               '{1'b1, 4'h0, 32'hFFFFFFFF, 20'hFFFFE, 1'b0});
        script(ACT_FIND, 32'h0, 20'h0, 24'h0FFFFF, 1'b0, NO_REPLY);
        script(ACT_FIND, 32'h0, 20'h0, 24'h100000, 1'b1, NO_REPLY);
        script(ACT_ADD, 32'h10000003, 20'h00003, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h10000004, 20'h00010, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h10000005, 20'h00000, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h10000006, 20'h00007, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h10000007, 20'h00100, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h10000008, 20'h00002, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h10000009, 20'h00001, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h1000000A, 20'h00040, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h1000000B, 20'h00005, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h1000000C, 20'h00000, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h1000000D, 20'h00011, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h1000000E, 20'h00008, 24'h0, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h1000000F, 20'h00020, 24'h0, 1'b1,
               '{1'b0, 4'h0, 32'h0, 20'h0, 1'b1});
        script(ACT_FIND, 32'h0, 20'h0, 24'h100001, 1'b0, NO_REPLY);
        script(ACT_ADD, 32'h5A5A5A5A, 20'h00007, 24'h0, 1'b1,
               '{1'b0, 4'h0, 32'h0, 20'h0, 1'b1});
        script(ACT_FIND, 32'h0, 20'h0, 24'hFFFFFF, 1'b1,
               '{1'b0, 4'h0, 32'h0, 20'h0, 1'b1});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        foreach (script_rows[i])
        begin
            row = script_rows[i];
            send_word(row.action, row.data_ref, row.size, row.offset, row.pinned, row.reply);
        end

        // Random words in blocks that lean toward adds, a mix, or finds.
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            case ((n / 100) % 3)
                0:       add_pct = 70;
                1:       add_pct = 50;
                default: add_pct = 30;
            endcase
            sender_may_idle = !(n >= 700 && n < 1000);
            act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_FIND;

            // Sizes are mostly small, with empty and maximal entries mixed in.
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                size = '0;
            end
            else if (pick < 18)
            begin
                size = '1;
            end
            else if (pick < 30)
            begin
                size = SIZE_W'($urandom());
            end
            else
            begin
                size = SIZE_W'($urandom_range(1, 64));
            end

            // Offsets aim inside the data, at entry edges and at its end.
            live  = live_entries();
            total = bytes_before(live);
            pick  = $urandom_range(0, 99);
            if (pick < 50)
            begin
                target = (total == 0) ? 32'h0 : 32'($urandom_range(0, total - 1));
            end
            else if (pick < 60)
            begin
                target = (total == 0) ? 32'h0 : total - 1;
            end
            else if (pick < 70)
            begin
                target = total + 32'($urandom_range(0, 3));
            end
            else if (pick < 85)
            begin
                target = bytes_before($urandom_range(0, live));
                if (target != 0 && $urandom_range(0, 1) == 1)
                begin
                    target = target - 1;
                end
            end
            else
            begin
                target = $urandom();
            end

            send_word(act, $urandom(), size, OFF_W'(target), 1'b0, NO_REPLY);
        end

        @(negedge clk);
        start <= 1'b0;

        // Wait for the last results, then leave room for any stray strobe.
        drain = 0;
        while (pending_replies.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (RING_SLOTS + 4) @(posedge clk);

        if (mismatch_count == 0 && pending_replies.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
